// File: rtl/drae_pkg.sv
package drae_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [2:0] STATUS_PARSED   = 3'd0;
  localparam logic [2:0] STATUS_SHORT    = 3'd1;
  localparam logic [2:0] STATUS_NOT_RESP = 3'd2;
  localparam logic [2:0] STATUS_RCODE    = 3'd3;
  localparam logic [2:0] STATUS_NO_ANS   = 3'd4;

  localparam logic KIND_ADDRESS = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [3:0]  HEADER_BYTES  = 4'd12;
  localparam logic [15:0] FLAG_RESPONSE = 16'h8000;
  localparam logic [15:0] FLAG_RCODE    = 16'h000F;
  localparam logic [7:0]  PTR_MASK      = 8'hC0;
  localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

  // One queue entry: what a single input byte caused.
  typedef struct packed {
    logic        has_address;
    logic        has_summary;
    logic [31:0] address_value;
    logic [2:0]  end_status;
    logic [15:0] address_count;
  } drae_event_t;

endpackage

// File: rtl/drae_if.sv
interface drae_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] message_byte;
  logic       last_byte;

  modport source(output valid, output message_byte, output last_byte, input ready);
  modport sink(input valid, input message_byte, input last_byte, output ready);
endinterface

interface drae_result_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [31:0] address_value;
  logic [2:0]  end_status;
  logic [15:0] address_count;
  logic        last_of_run;

  modport source(output valid, output result_kind, output address_value,
                 output end_status, output address_count, output last_of_run,
                 input ready);
  modport sink(input valid, input result_kind, input address_value,
               input end_status, input address_count, input last_of_run,
               output ready);
endinterface

// File: rtl/dns_response_a_record_extractor.sv
// An event is queued, and parser state updates, in the cycle its byte is accepted.
// Throughput: one byte per cycle while the queue is not full.
// A byte that yields an address and the summary gives two results; the
// QUEUE_DEPTH-entry event queue between parser and output absorbs that.
// Reset: synchronous rst returns the parser to the header phase and empties the queue.
module dns_response_a_record_extractor
  import drae_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  drae_byte_if.sink     message,
  drae_result_if.source result
);

  logic        accept;
  logic        push;
  logic        full;
  logic        pop;
  logic        not_empty;
  drae_event_t push_event;
  drae_event_t head_event;

  assign message.ready = !full;
  assign accept        = message.valid && !full;

  drae_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .message_byte (message.message_byte),
    .last_byte    (message.last_byte),
    .push         (push),
    .push_event   (push_event)
  );

  drae_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_event (push_event),
    .full       (full),
    .pop        (pop),
    .not_empty  (not_empty),
    .head_event (head_event)
  );

  drae_back u_back (
    .clk        (clk),
    .rst        (rst),
    .not_empty  (not_empty),
    .head_event (head_event),
    .pop        (pop),
    .result     (result)
  );

endmodule

// File: rtl/drae_front.sv
module drae_front
  import drae_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  message_byte,
  input  logic        last_byte,
  output logic        push,
  output drae_event_t push_event
);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_QNAME  = 3'd1;
  localparam logic [2:0] PH_QFIXED = 3'd2;
  localparam logic [2:0] PH_ANAME  = 3'd3;
  localparam logic [2:0] PH_AFIXED = 3'd4;
  localparam logic [2:0] PH_RDATA  = 3'd5;
  localparam logic [2:0] PH_DONE   = 3'd6;

  logic [3:0]  header_position, header_position_next;
  logic [15:0] header_word, header_word_next;
  logic [15:0] questions_left, questions_left_next;
  logic [15:0] answers_left, answers_left_next;
  logic [2:0]  parse_phase, parse_phase_next;
  logic [15:0] skip_left, skip_left_next;
  logic [3:0]  fixed_position, fixed_position_next;
  logic [15:0] record_type, record_type_next;
  logic [15:0] record_class, record_class_next;
  logic [31:0] address_shift, address_shift_next;
  logic        record_qualifies, record_qualifies_next;
  logic [15:0] found_count, found_count_next;
  logic [2:0]  message_status, message_status_next;

  logic        emit_address;
  logic        name_done;
  logic [15:0] answers_dec;

  always_comb begin
    header_position_next  = header_position;
    header_word_next      = header_word;
    questions_left_next   = questions_left;
    answers_left_next     = answers_left;
    parse_phase_next      = parse_phase;
    skip_left_next        = skip_left;
    fixed_position_next   = fixed_position;
    record_type_next      = record_type;
    record_class_next     = record_class;
    address_shift_next    = address_shift;
    record_qualifies_next = record_qualifies;
    found_count_next      = found_count;
    message_status_next   = message_status;
    emit_address          = 1'b0;
    name_done             = 1'b0;
    answers_dec           = answers_left - 16'd1;

    // label / zero end / pointer walk, shared by question and answer names
    if (skip_left != 16'd0) begin
      skip_left_next = skip_left - 16'd1;
      name_done = (skip_left == 16'd1) && (fixed_position == 4'd1);
    end else if (message_byte == 8'h00) begin
      name_done = 1'b1;
    end else if ((message_byte & PTR_MASK) == PTR_MASK) begin
      skip_left_next      = 16'd1;
      fixed_position_next = 4'd1;
    end else begin
      skip_left_next      = {8'h00, message_byte};
      fixed_position_next = 4'd0;
    end

    unique case (parse_phase)
      PH_HEADER: begin
        skip_left_next      = skip_left;
        fixed_position_next = fixed_position;
        if (header_position[0]) begin
          header_word_next = {header_word[7:0], message_byte};
        end else begin
          header_word_next = {8'h00, message_byte};
        end
        if (header_position == 4'd3) begin
          if ((header_word_next & FLAG_RESPONSE) == 16'd0) begin
            message_status_next = STATUS_NOT_RESP;
          end else if ((header_word_next & FLAG_RCODE) != 16'd0) begin
            message_status_next = STATUS_RCODE;
          end
        end else if (header_position == 4'd5) begin
          questions_left_next = header_word_next;
        end else if (header_position == 4'd7) begin
          answers_left_next = header_word_next;
          if (header_word_next == 16'd0 && message_status == STATUS_PARSED) begin
            message_status_next = STATUS_NO_ANS;
          end
        end
        header_position_next = header_position + 4'd1;
        if (header_position_next >= HEADER_BYTES) begin
          header_position_next = HEADER_BYTES;
          if (message_status_next != STATUS_PARSED) begin
            parse_phase_next = PH_DONE;
          end else if (questions_left_next != 16'd0) begin
            parse_phase_next = PH_QNAME;
          end else begin
            parse_phase_next = PH_ANAME;
          end
          skip_left_next      = 16'd0;
          fixed_position_next = 4'd0;
        end
      end
      PH_QNAME, PH_ANAME: begin
        if (name_done) begin
          parse_phase_next    = (parse_phase == PH_QNAME) ? PH_QFIXED : PH_AFIXED;
          fixed_position_next = 4'd0;
        end
      end
      PH_QFIXED: begin
        skip_left_next = skip_left;
        if (fixed_position >= 4'd3) begin
          questions_left_next = questions_left - 16'd1;
          parse_phase_next    = (questions_left_next != 16'd0) ? PH_QNAME : PH_ANAME;
          fixed_position_next = 4'd0;
          skip_left_next      = 16'd0;
        end else begin
          fixed_position_next = fixed_position + 4'd1;
        end
      end
      PH_AFIXED: begin
        skip_left_next = skip_left;
        if (fixed_position < 4'd2) begin
          record_type_next = {record_type[7:0], message_byte};
        end else if (fixed_position < 4'd4) begin
          record_class_next = {record_class[7:0], message_byte};
        end else if (fixed_position >= 4'd8) begin
          skip_left_next = {skip_left[7:0], message_byte};
        end
        if (fixed_position >= 4'd9) begin
          record_qualifies_next = (record_type_next == 16'd1) &&
                                  (record_class_next == 16'd1) &&
                                  (skip_left_next == 16'd4);
          address_shift_next  = 32'd0;
          fixed_position_next = 4'd0;
          if (skip_left_next == 16'd0) begin
            answers_left_next = answers_dec;
            parse_phase_next  = (answers_dec != 16'd0) ? PH_ANAME : PH_DONE;
          end else begin
            parse_phase_next = PH_RDATA;
          end
        end else begin
          fixed_position_next = fixed_position + 4'd1;
        end
      end
      PH_RDATA: begin
        fixed_position_next = fixed_position;
        if (record_qualifies) begin
          address_shift_next = {address_shift[23:0], message_byte};
        end
        if (skip_left != 16'd0) begin
          skip_left_next = skip_left - 16'd1;
        end else begin
          skip_left_next = skip_left;
        end
        if (skip_left_next == 16'd0) begin
          if (record_qualifies) begin
            if (found_count != COUNT_MAX) begin
              found_count_next = found_count + 16'd1;
            end
            emit_address = 1'b1;
          end
          record_qualifies_next = 1'b0;
          answers_left_next     = answers_dec;
          parse_phase_next      = (answers_dec != 16'd0) ? PH_ANAME : PH_DONE;
          fixed_position_next   = 4'd0;
          skip_left_next        = 16'd0;
        end
      end
      default: begin
        skip_left_next      = skip_left;
        fixed_position_next = fixed_position;
      end
    endcase
  end

  always_comb begin
    push_event.has_address   = emit_address;
    push_event.has_summary   = last_byte;
    push_event.address_value = address_shift_next;
    push_event.end_status    = (header_position_next < HEADER_BYTES) ? STATUS_SHORT
                                                                     : message_status_next;
    push_event.address_count = found_count_next;
    push = accept && (emit_address || last_byte);
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      header_position  <= 4'd0;
      header_word      <= 16'd0;
      questions_left   <= 16'd0;
      answers_left     <= 16'd0;
      parse_phase      <= PH_HEADER;
      skip_left        <= 16'd0;
      fixed_position   <= 4'd0;
      record_type      <= 16'd0;
      record_class     <= 16'd0;
      address_shift    <= 32'd0;
      record_qualifies <= 1'b0;
      found_count      <= 16'd0;
      message_status   <= STATUS_PARSED;
    end else if (accept) begin
      header_position  <= header_position_next;
      header_word      <= header_word_next;
      questions_left   <= questions_left_next;
      answers_left     <= answers_left_next;
      parse_phase      <= parse_phase_next;
      skip_left        <= skip_left_next;
      fixed_position   <= fixed_position_next;
      record_type      <= record_type_next;
      record_class     <= record_class_next;
      address_shift    <= address_shift_next;
      record_qualifies <= record_qualifies_next;
      found_count      <= found_count_next;
      message_status   <= message_status_next;
    end
  end

endmodule

// File: rtl/drae_queue.sv
module drae_queue
  import drae_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  drae_event_t push_event,
  output logic        full,
  input  logic        pop,
  output logic        not_empty,
  output drae_event_t head_event
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  drae_event_t       slots [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CW-1:0]     fill;

  assign full       = (fill == CW'(DEPTH));
  assign not_empty  = (fill != CW'(0));
  assign head_event = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_event;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

// File: rtl/drae_back.sv
module drae_back
  import drae_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             not_empty,
  input  drae_event_t      head_event,
  output logic             pop,
  drae_result_if.source    result
);

  // set once the address half of a two-result entry has gone out
  logic address_sent;
  logic show_address;
  logic taken;

  assign show_address = head_event.has_address && !address_sent;
  assign taken        = result.valid && result.ready;

  always_comb begin
    result.valid         = not_empty;
    result.result_kind   = show_address ? KIND_ADDRESS : KIND_SUMMARY;
    result.address_value = show_address ? head_event.address_value : 32'd0;
    result.end_status    = show_address ? STATUS_PARSED : head_event.end_status;
    result.address_count = head_event.address_count;
    result.last_of_run   = show_address ? !head_event.has_summary : 1'b1;
    pop = taken && !(show_address && head_event.has_summary);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      address_sent <= 1'b0;
    end else if (taken) begin
      address_sent <= show_address && head_event.has_summary;
    end
  end

endmodule
